// ----- rtl/core/csrmv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrmv_pkg: shared types and constants
// Command codes, transaction structs and the queue entry format used by the
// sparse matrix-vector product block.
// ----------------------------------------------------------------------------
package csrmv_pkg;

    localparam int MAX_ROWS_DEF  = 1024;
    localparam int OPQ_DEPTH_DEF = 4;

    localparam int INDEX_W  = 10;
    localparam int VALUE_W  = 17;
    localparam int SCALE_W  = 17;
    localparam int ROWS_W   = 11;
    localparam int PROD_W   = 2 * VALUE_W;
    localparam int ACC_W    = 44;
    localparam int HALF_W   = ACC_W / 2;
    localparam int PART_W   = HALF_W + SCALE_W;
    localparam int TOTAL_W  = ACC_W + SCALE_W;
    localparam int FRAC_SH  = 32;
    localparam int SCALED_W = TOTAL_W - FRAC_SH;
    localparam int RESULT_W = 24;
    localparam int ROW_W    = 10;
    localparam int CNT_EXT_W = 17;

    localparam logic [ACC_W-1:0]    ACC_MAX    = {ACC_W{1'b1}};
    localparam logic [RESULT_W-1:0] RESULT_MAX = {RESULT_W{1'b1}};

    localparam logic [SCALE_W-1:0] SCALE_RESET = 17'd65536;
    localparam logic [ROWS_W-1:0]  ROWS_RESET  = 11'd1024;

    typedef enum logic [1:0] {
        CMD_LOAD      = 2'd0,
        CMD_NONZERO   = 2'd1,
        CMD_EMPTY_ROW = 2'd2,
        CMD_NEW_PASS  = 2'd3
    } cmd_t;

    localparam logic REG_SCALE_FACTOR = 1'b0;
    localparam logic REG_ROWS_IN_USE  = 1'b1;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
        logic               row_end;
    } item_t;

    typedef struct packed {
        logic [ROW_W-1:0]    row;
        logic [RESULT_W-1:0] result;
        logic                saturated;
        logic                last;
    } entry_t;

    // One queued operation for the accumulator side
    typedef struct packed {
        logic              clear;
        logic              close;
        logic [PROD_W-1:0] prod;
    } op_t;

    typedef struct packed {
        logic avail;
        op_t  op;
    } opq_head_t;

endpackage

// ----- rtl/core/csrmv_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrmv_front: command decode, vector store and product stage
// Writes vector elements, reads the element for each nonzero, forms the
// product and pushes one operation per non-load command into the queue.
// ----------------------------------------------------------------------------
module csrmv_front
    import csrmv_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  accept,
    input  item_t item,
    output logic  op_push,
    output op_t   op,
    output logic [1:0] in_flight
);

    localparam int STORE_DEPTH = (MAX_ROWS < 1024) ? MAX_ROWS : 1024;
    localparam int AW          = $clog2(STORE_DEPTH);

    logic [VALUE_W-1:0] store_mem [STORE_DEPTH];
    logic [VALUE_W-1:0] elem_reg;

    logic               f1_valid_reg;
    logic [1:0]         f1_cmd_reg;
    logic [VALUE_W-1:0] f1_val_reg;
    logic               f1_end_reg;
    logic               f1_inrange_reg;

    logic               f2_valid_reg;
    op_t                f2_op_reg;

    logic               in_range;
    logic [AW-1:0]      addr;
    logic [VALUE_W-1:0] elem;
    op_t                op_next;

    assign in_range = (MAX_ROWS >= 1024) || (32'(item.index) < MAX_ROWS);
    assign addr     = item.index[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (accept && item.cmd == CMD_LOAD && in_range)
        begin
            store_mem[addr] <= item.value;
        end
        if (accept)
        begin
            elem_reg <= store_mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= accept && item.cmd != CMD_LOAD;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_cmd_reg     <= item.cmd;
            f1_val_reg     <= item.value;
            f1_end_reg     <= item.row_end;
            f1_inrange_reg <= in_range;
        end
        f2_op_reg <= op_next;
    end

    // Drop the element for a column outside the store
    assign elem = f1_inrange_reg ? elem_reg : '0;

    always_comb
    begin
        op_next       = '0;
        op_next.clear = (f1_cmd_reg == CMD_NEW_PASS);
        op_next.close = (f1_cmd_reg == CMD_EMPTY_ROW)
                     || (f1_cmd_reg == CMD_NONZERO && f1_end_reg);
        if (f1_cmd_reg == CMD_NONZERO)
        begin
            op_next.prod = PROD_W'(f1_val_reg) * PROD_W'(elem);
        end
    end

    assign op_push   = f2_valid_reg;
    assign op        = f2_op_reg;
    assign in_flight = {1'b0, f1_valid_reg} + {1'b0, f2_valid_reg};

endmodule

// ----- rtl/core/csrmv_opq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrmv_opq: operation queue
// Small first-in first-out buffer between the product stage and the
// accumulator, so each side can stall on its own.
// ----------------------------------------------------------------------------
module csrmv_opq
    import csrmv_pkg::*;
#(
    parameter int DEPTH = OPQ_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  op_t       op,
    input  logic      pop,
    output opq_head_t head,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    op_t           mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign head.avail = (count_reg != '0);
    assign head.op    = mem[rd_ptr_reg];
    assign count      = count_reg;

endmodule

// ----- rtl/core/csrmv_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrmv_back: row accumulator and result scaling
// Adds products into the saturating row sum, closes rows, scales the sum
// by split partial products and holds the result for the receiver.
// ----------------------------------------------------------------------------
module csrmv_back
    import csrmv_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  opq_head_t          head,
    output logic               op_pop,
    input  logic [SCALE_W-1:0] scale_factor,
    input  logic [ROWS_W-1:0]  rows_in_use,
    output logic               empty,
    input  logic               pop,
    output entry_t             entry
);

    localparam int RW = $clog2(MAX_ROWS);

    logic [ACC_W-1:0]     acc_reg;
    logic                 clip_reg;
    logic [RW-1:0]        row_cnt_reg;

    logic                 s1_valid_reg;
    logic [ACC_W-1:0]     s1_acc_reg;
    logic                 s1_clip_reg;
    logic [ROW_W-1:0]     s1_row_reg;
    logic                 s1_last_reg;

    logic                 s2_valid_reg;
    logic [PART_W-1:0]    s2_hi_reg;
    logic [PART_W-1:0]    s2_lo_reg;
    logic                 s2_clip_reg;
    logic [ROW_W-1:0]     s2_row_reg;
    logic                 s2_last_reg;

    logic                 out_valid_reg;
    entry_t               out_reg;

    logic                 adv;
    logic                 take;
    logic [ACC_W:0]       sum;
    logic [ACC_W-1:0]     acc_next;
    logic                 clip_next;
    logic [CNT_EXT_W-1:0] rows_ext;
    logic [CNT_EXT_W-1:0] last_idx;
    logic [CNT_EXT_W-1:0] cnt_ext;
    logic                 is_last;
    logic                 wrap;
    logic [TOTAL_W-1:0]   total;
    logic [SCALED_W-1:0]  scaled;
    logic                 over;

    // Hold the whole back side while a result waits
    assign adv    = !out_valid_reg || pop;
    assign take   = adv && head.avail;
    assign op_pop = take;

    assign sum       = {1'b0, acc_reg} + (ACC_W + 1)'(head.op.prod);
    assign acc_next  = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
    assign clip_next = clip_reg || sum[ACC_W];

    assign rows_ext = CNT_EXT_W'(rows_in_use);
    always_comb
    begin
        if (rows_ext == '0)
        begin
            last_idx = '0;
        end
        else if (32'(rows_ext) > MAX_ROWS)
        begin
            last_idx = CNT_EXT_W'(MAX_ROWS - 1);
        end
        else
        begin
            last_idx = rows_ext - 1'b1;
        end
    end

    assign cnt_ext = CNT_EXT_W'(row_cnt_reg);
    assign is_last = (cnt_ext == last_idx);
    assign wrap    = is_last || (cnt_ext == CNT_EXT_W'(MAX_ROWS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            clip_reg      <= 1'b0;
            row_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= take && !head.op.clear && head.op.close;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
            if (take)
            begin
                if (head.op.clear)
                begin
                    acc_reg     <= '0;
                    clip_reg    <= 1'b0;
                    row_cnt_reg <= '0;
                end
                else if (head.op.close)
                begin
                    acc_reg     <= '0;
                    clip_reg    <= 1'b0;
                    row_cnt_reg <= wrap ? '0 : row_cnt_reg + 1'b1;
                end
                else
                begin
                    acc_reg  <= acc_next;
                    clip_reg <= clip_next;
                end
            end
        end
    end

    assign total  = (TOTAL_W'(s2_hi_reg) << HALF_W) + TOTAL_W'(s2_lo_reg);
    assign scaled = total[TOTAL_W-1:FRAC_SH];
    assign over   = |scaled[SCALED_W-1:RESULT_W];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_acc_reg  <= acc_next;
            s1_clip_reg <= clip_next;
            s1_row_reg  <= cnt_ext[ROW_W-1:0];
            s1_last_reg <= is_last;

            s2_hi_reg   <= PART_W'(s1_acc_reg[ACC_W-1:HALF_W]) * PART_W'(scale_factor);
            s2_lo_reg   <= PART_W'(s1_acc_reg[HALF_W-1:0]) * PART_W'(scale_factor);
            s2_clip_reg <= s1_clip_reg;
            s2_row_reg  <= s1_row_reg;
            s2_last_reg <= s1_last_reg;

            out_reg.row       <= s2_row_reg;
            out_reg.result    <= over ? RESULT_MAX : scaled[RESULT_W-1:0];
            out_reg.saturated <= s2_clip_reg || over;
            out_reg.last      <= s2_last_reg;
        end
    end

    assign empty = !out_valid_reg;
    assign entry = out_reg;

endmodule

// ----- rtl/core/csr_sparse_matvec.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_sparse_matvec: sparse matrix-vector product, compressed-row order
// Load vector elements, then stream nonzeros row by row; each closed row
// gives one scaled, saturated row sum with its row number.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive item and raise push; the transaction is taken on a
//   clock edge with push high and full low. Commands: load element, matrix
//   nonzero (row_end closes the row), empty row, start new pass.
//   Result queue: while empty is low, entry holds the oldest result; raise
//   pop to take it. last marks the final row of the pass.
//   Configuration: cfg_write with cfg_index selects scale_factor (0) or
//   rows_in_use (1); write only while the block is idle.
//   A closing transaction passes the product stages, queue, s1, s2 and
//   output register to entry. Throughput is one transaction per cycle while
//   results are taken, set by the accumulate add; the operation queue holds
//   OPQ_DEPTH entries counted together with two in-flight product stages.
//   When the receiver stalls, the held result freezes the accumulator and
//   scaling stages; the queue fills and full rises.
//   Reset clears the row sum, row counter and queues and restores the
//   register defaults; vector store contents are undefined until loaded.
// ----------------------------------------------------------------------------
module csr_sparse_matvec
    import csrmv_pkg::*;
#(
    parameter int MAX_ROWS  = MAX_ROWS_DEF,
    parameter int OPQ_DEPTH = OPQ_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  item_t              item,
    output logic               empty,
    input  logic               pop,
    output entry_t             entry,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [SCALE_W-1:0] cfg_data
);

    localparam int CW = $clog2(OPQ_DEPTH + 1);

    logic [SCALE_W-1:0] scale_factor_reg;
    logic [ROWS_W-1:0]  rows_in_use_reg;

    logic          accept;
    logic          op_push;
    op_t           op;
    logic [1:0]    in_flight;
    opq_head_t     head;
    logic          op_pop;
    logic [CW-1:0] opq_count;
    logic [CW+1:0] reserved;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_factor_reg <= SCALE_RESET;
            rows_in_use_reg  <= ROWS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SCALE_FACTOR: scale_factor_reg <= cfg_data;
                REG_ROWS_IN_USE:  rows_in_use_reg  <= cfg_data[ROWS_W-1:0];
                default:          ;
            endcase
        end
    end

    // Count entries in the queue plus those still in the product stages
    assign reserved = (CW + 2)'(opq_count) + (CW + 2)'(in_flight);
    assign full     = (32'(reserved) >= OPQ_DEPTH);
    assign accept   = push && !full;

    csrmv_front #(
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .op_push   (op_push),
        .op        (op),
        .in_flight (in_flight)
    );

    csrmv_opq #(
        .DEPTH (OPQ_DEPTH)
    ) u_opq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (op_push),
        .op    (op),
        .pop   (op_pop),
        .head  (head),
        .count (opq_count)
    );

    csrmv_back #(
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .op_pop       (op_pop),
        .scale_factor (scale_factor_reg),
        .rows_in_use  (rows_in_use_reg),
        .empty        (empty),
        .pop          (pop),
        .entry        (entry)
    );

endmodule

// ----- tb/sv/tb_csr_sparse_matvec.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_csr_sparse_matvec: self-checking bench for the sparse matrix-vector block
// Streams element loads, nonzeros, empty rows and pass restarts through the
// input queue, predicts every row result in a local model of the datapath
// and compares each popped entry field by field. Covers register extremes,
// result and accumulator saturation, pass wrap and random handshake gaps.
// ----------------------------------------------------------------------------
module tb_csr_sparse_matvec;
    import csrmv_pkg::*;

    localparam int STORE_DEPTH  = MAX_ROWS_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int VALUE_TOP    = (1 << VALUE_W) - 1;
    localparam int INDEX_TOP    = (1 << INDEX_W) - 1;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               push;
    logic               full;
    item_t              item;
    logic               empty;
    logic               pop;
    entry_t             entry;
    logic               cfg_write;
    logic               cfg_index;
    logic [SCALE_W-1:0] cfg_data;

    csr_sparse_matvec dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .entry     (entry),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Local copy of the datapath state
    logic [VALUE_W-1:0] elem_mem [STORE_DEPTH];
    bit                 elem_loaded [STORE_DEPTH];
    int unsigned        loaded_cols [$];
    logic [ACC_W-1:0]   row_sum;
    logic               sum_clipped;
    logic [ROW_W-1:0]   row_num;
    logic [SCALE_W-1:0] scale_reg;
    logic [ROWS_W-1:0]  rows_reg;
    entry_t             row_results_q [$];

    int  mismatches;
    int  items_sent;
    int  cycle_count;
    int  rx_stall;
    bit  tx_gap_on;
    bit  rx_gap_on;
    entry_t want;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic item_t make_item(cmd_t c, int unsigned idx, int unsigned val, bit last_nz);
        item_t m;
        m.cmd     = c;
        m.index   = idx[INDEX_W-1:0];
        m.value   = val[VALUE_W-1:0];
        m.row_end = last_nz;
        return m;
    endfunction

    function automatic int unsigned pick_col();
        return loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
    endfunction

    function automatic int unsigned rand_value();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return VALUE_TOP;
            2:       return 65536;
            3, 4, 5: return $urandom_range(0, VALUE_TOP);
            default: return $urandom_range(0, 1024);
        endcase
    endfunction

    // Scale, saturate and emit the pending row sum, then advance the row number
    function automatic entry_t close_row_sum();
        logic [TOTAL_W-1:0] wide;
        logic [TOTAL_W-1:0] scaled;
        int                 eff_rows;
        entry_t             e;
        wide   = TOTAL_W'(row_sum) * TOTAL_W'(scale_reg);
        scaled = wide >> FRAC_SH;
        if (rows_reg == 0)
            eff_rows = 1;
        else if (rows_reg > MAX_ROWS_DEF)
            eff_rows = MAX_ROWS_DEF;
        else
            eff_rows = int'(rows_reg);
        e.row       = row_num;
        e.saturated = sum_clipped;
        e.last      = (int'(row_num) == eff_rows - 1);
        if (scaled > TOTAL_W'(RESULT_MAX))
        begin
            e.result    = RESULT_MAX;
            e.saturated = 1'b1;
        end
        else
        begin
            e.result = scaled[RESULT_W-1:0];
        end
        row_sum     = '0;
        sum_clipped = 1'b0;
        if (e.last || int'(row_num) == MAX_ROWS_DEF - 1)
            row_num = '0;
        else
            row_num = row_num + 1'b1;
        return e;
    endfunction

    task automatic queue_result(input entry_t e);
        row_results_q = {row_results_q, e};
    endtask

    task automatic predict_item(input item_t it);
        logic [PROD_W-1:0] prod;
        case (it.cmd)
            CMD_LOAD:
            begin
                elem_mem[it.index] = it.value;
                if (!elem_loaded[it.index])
                begin
                    elem_loaded[it.index] = 1'b1;
                    loaded_cols = {loaded_cols, 32'(it.index)};
                end
            end
            CMD_NONZERO:
            begin
                prod = PROD_W'(it.value) * PROD_W'(elem_mem[it.index]);
                if (ACC_W'(prod) > ACC_MAX - row_sum)
                begin
                    row_sum     = ACC_MAX;
                    sum_clipped = 1'b1;
                end
                else
                begin
                    row_sum = row_sum + ACC_W'(prod);
                end
                if (it.row_end)
                    queue_result(close_row_sum());
            end
            CMD_EMPTY_ROW:
                queue_result(close_row_sum());
            default:
            begin
                row_sum     = '0;
                sum_clipped = 1'b0;
                row_num     = '0;
            end
        endcase
    endtask

    task automatic note_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // Result side: check every popped transaction against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (row_results_q.size() == 0)
                begin
                    note_error($sformatf("unexpected entry row=%0d result=%0d sat=%0b last=%0b",
                                         entry.row, entry.result, entry.saturated, entry.last));
                end
                else
                begin
                    want = row_results_q.pop_front();
                    if (entry.row !== want.row || entry.result !== want.result ||
                        entry.saturated !== want.saturated || entry.last !== want.last)
                    begin
                        note_error($sformatf({"expected row=%0d result=%0d sat=%0b last=%0b, ",
                                              "got row=%0d result=%0d sat=%0b last=%0b"},
                                             want.row, want.result, want.saturated, want.last,
                                             entry.row, entry.result, entry.saturated,
                                             entry.last));
                    end
                end
            end
            if (rx_stall > 0)
            begin
                pop <= 1'b0;
                rx_stall--;
            end
            else
            begin
                pop <= 1'b1;
                if (rx_gap_on)
                    rx_stall = pick_gap();
            end
        end
    end

    // Hold push until the transaction is taken; keep it high when no gap follows
    task automatic send_item(input item_t it);
        int gap;
        item <= it;
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_item(it);
        items_sent++;
        gap = tx_gap_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle();
        push <= 1'b0;
        while (row_results_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [SCALE_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (idx == REG_SCALE_FACTOR)
            scale_reg = data;
        else
            rows_reg = data[ROWS_W-1:0];
    endtask

    task automatic send_junk(input cmd_t c);
        send_item(make_item(c, $urandom_range(0, INDEX_TOP), $urandom_range(0, VALUE_TOP),
                            1'($urandom_range(0, 1))));
    endtask

    task automatic send_row(input int len);
        int k;
        if (len == 0)
        begin
            send_junk(CMD_EMPTY_ROW);
        end
        else
        begin
            for (k = 0; k < len; k++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_item(make_item(CMD_LOAD, $urandom_range(0, INDEX_TOP), rand_value(),
                                        1'($urandom_range(0, 1))));
                send_item(make_item(CMD_NONZERO, pick_col(), rand_value(), k == len - 1));
            end
        end
    endtask

    // Long row of large products against a freshly loaded large element
    task automatic send_heavy_row();
        int unsigned col;
        int          len;
        int          k;
        col = $urandom_range(0, INDEX_TOP);
        len = $urandom_range(30, 70);
        send_item(make_item(CMD_LOAD, col, $urandom_range(VALUE_TOP - 4096, VALUE_TOP), 1'b0));
        for (k = 0; k < len; k++)
            send_item(make_item(CMD_NONZERO, col, $urandom_range(VALUE_TOP - 8192, VALUE_TOP),
                                k == len - 1));
    endtask

    task automatic test_directed();
        send_junk(CMD_NEW_PASS);
        send_item(make_item(CMD_LOAD, 0, VALUE_TOP, 1'b0));
        send_item(make_item(CMD_LOAD, INDEX_TOP, 65536, 1'b0));
        send_item(make_item(CMD_LOAD, 512, 0, 1'b0));
        send_item(make_item(CMD_LOAD, 341, 1, 1'b0));
        send_item(make_item(CMD_LOAD, 682, VALUE_TOP, 1'b1));
        send_item(make_item(CMD_NONZERO, 0, VALUE_TOP, 1'b1));
        send_item(make_item(CMD_NONZERO, INDEX_TOP, 65536, 1'b0));
        send_item(make_item(CMD_NONZERO, 341, VALUE_TOP, 1'b1));
        send_item(make_item(CMD_NONZERO, 512, VALUE_TOP, 1'b1));
        send_item(make_item(CMD_NONZERO, 0, 0, 1'b1));
        send_item(make_item(CMD_EMPTY_ROW, INDEX_TOP, VALUE_TOP, 1'b1));
        // close a pending sum with an empty-row command
        send_item(make_item(CMD_NONZERO, INDEX_TOP, 1, 1'b0));
        send_item(make_item(CMD_EMPTY_ROW, 0, 0, 1'b0));
        // drop a pending sum with a new pass
        send_item(make_item(CMD_NONZERO, 0, VALUE_TOP, 1'b0));
        send_item(make_item(CMD_NEW_PASS, 682, VALUE_TOP, 1'b1));
        send_item(make_item(CMD_NONZERO, 341, 5, 1'b1));
        send_item(make_item(CMD_NONZERO, 682, 65536, 1'b1));
        send_item(make_item(CMD_NONZERO, 682, VALUE_TOP, 1'b0));
        send_item(make_item(CMD_NONZERO, 0, VALUE_TOP, 1'b1));
    endtask

    task automatic run_phase(input logic [SCALE_W-1:0] scale, input logic [ROWS_W-1:0] rows,
                             input int n_items, input bit tx_on, input bit rx_on);
        int start;
        int r;
        int k;
        settle();
        write_reg(REG_SCALE_FACTOR, scale);
        write_reg(REG_ROWS_IN_USE, SCALE_W'(rows));
        tx_gap_on = tx_on;
        rx_gap_on = rx_on;
        start = items_sent;
        if ($urandom_range(0, 9) < 7)
            send_junk(CMD_NEW_PASS);
        while (items_sent - start < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                for (k = $urandom_range(1, 4); k > 0; k--)
                    send_item(make_item(CMD_LOAD, $urandom_range(0, INDEX_TOP), rand_value(),
                                        1'($urandom_range(0, 1))));
            end
            else if (r < 11)
            begin
                send_junk(CMD_NEW_PASS);
            end
            else if (r < 16)
            begin
                case ($urandom_range(0, 3))
                    0:       send_item(make_item(CMD_LOAD, $urandom_range(0, INDEX_TOP),
                                                 $urandom_range(0, VALUE_TOP),
                                                 1'($urandom_range(0, 1))));
                    1:       send_item(make_item(CMD_NONZERO, pick_col(),
                                                 $urandom_range(0, VALUE_TOP),
                                                 1'($urandom_range(0, 1))));
                    2:       send_junk(CMD_EMPTY_ROW);
                    default: send_junk(CMD_NEW_PASS);
                endcase
            end
            else if (r < 18)
            begin
                send_heavy_row();
            end
            else if (r < 35)
            begin
                send_row(0);
            end
            else
            begin
                send_row($urandom_range(1, 6));
            end
        end
    endtask

    task automatic test_register_sweep();
        run_phase(17'd65536, 11'd4, 10, 1'b1, 1'b1);
        run_phase(17'd0, 11'd1, 10, 1'b1, 1'b1);
        run_phase(17'h1FFFF, 11'd2047, 10, 1'b0, 1'b0);
        run_phase(SCALE_W'($urandom_range(0, VALUE_TOP)), 11'd0, 10, 1'b1, 1'b0);
        run_phase(17'd1, 11'd1025, 10, 1'b0, 1'b1);
        run_phase(17'd65535, ROWS_W'($urandom_range(1, 40)), 10, 1'b1, 1'b1);
        run_phase(SCALE_W'($urandom_range(0, VALUE_TOP)), 11'd7, 10, 1'b1, 1'b1);
    endtask

    // Drive the row sum into its clip, then check the clip clears on the next row
    task automatic test_acc_clip();
        int k;
        settle();
        write_reg(REG_SCALE_FACTOR, 17'd1);
        write_reg(REG_ROWS_IN_USE, 17'd3);
        tx_gap_on = 1'b0;
        rx_gap_on = 1'b0;
        send_junk(CMD_NEW_PASS);
        send_item(make_item(CMD_LOAD, 777, VALUE_TOP, 1'b0));
        for (k = 0; k < 1030; k++)
            send_item(make_item(CMD_NONZERO, 777, VALUE_TOP, k == 1029));
        send_item(make_item(CMD_NONZERO, 777, 3, 1'b1));
        send_row(0);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        push        = 1'b0;
        item        = '0;
        pop         = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = REG_SCALE_FACTOR;
        cfg_data    = '0;
        row_sum     = '0;
        sum_clipped = 1'b0;
        row_num     = '0;
        scale_reg   = SCALE_RESET;
        rows_reg    = ROWS_RESET;
        mismatches  = 0;
        items_sent  = 0;
        cycle_count = 0;
        rx_stall    = 0;
        tx_gap_on   = 1'b1;
        rx_gap_on   = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_register_sweep();
        test_acc_clip();
        settle();

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
